/* hdl/pbce_pkg.sv */
// Shared types, codes and sizes of the piece bitmap claim engine.
package pbce_pkg;

  localparam int MAP_BYTES     = 128;
  localparam int BITS_PER_WORD = 8;
  localparam int PIECE_W       = 10;
  localparam int WORD_W        = 7;
  localparam int BIT_W         = $clog2(BITS_PER_WORD);
  localparam int COUNT_W       = 11;
  localparam int MAP_AW        = $clog2(MAP_BYTES);
  localparam int QDEPTH        = 2;
  localparam int QPTR_W        = $clog2(QDEPTH);
  localparam int QCNT_W        = $clog2(QDEPTH + 1);

  localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(1024);
  localparam logic [COUNT_W-1:0] USABLE_CAP  = COUNT_W'(MAP_BYTES * BITS_PER_WORD);

  localparam logic [1:0] REQ_SET   = 2'd0;
  localparam logic [1:0] REQ_CLEAR = 2'd1;
  localparam logic [1:0] REQ_CLAIM = 2'd2;
  localparam logic [1:0] REQ_CHECK = 2'd3;

  localparam logic KIND_CLAIM = 1'b0;
  localparam logic KIND_CHECK = 1'b1;

  typedef enum logic [1:0] {
    OP_SET,
    OP_CLEAR,
    OP_CLAIM,
    OP_CHECK
  } op_t;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [PIECE_W-1:0] piece_num;
    logic [7:0]         peer_word;
    logic [WORD_W-1:0]  word_index;
    logic               last_word;
  } req_t;

  typedef struct packed {
    logic               answer_kind;
    logic               found;
    logic [PIECE_W-1:0] claimed_piece;
    logic               complete;
  } resp_t;

  typedef struct packed {
    op_t                      op;
    logic [MAP_AW-1:0]        addr;
    logic [BIT_W-1:0]         bit_sel;
    logic [BITS_PER_WORD-1:0] peer;
    logic                     last;
    logic                     in_range;
  } cmd_t;

endpackage

/* hdl/pbce_front.sv */
// Request decoder that accepts requests and turns them into queued commands.
module pbce_front (
  input  logic           in_valid,
  output logic           in_ready,
  input  pbce_pkg::req_t in_data,
  input  logic           full,
  output logic           push,
  output pbce_pkg::cmd_t cmd
);
  import pbce_pkg::*;

  logic [WORD_W-1:0] word;

  assign in_ready = !full;
  assign push     = in_valid && !full;

  always_comb begin
    case (in_data.req_type)
      REQ_SET:   cmd.op = OP_SET;
      REQ_CLEAR: cmd.op = OP_CLEAR;
      REQ_CLAIM: cmd.op = OP_CLAIM;
      default:   cmd.op = OP_CHECK;
    endcase
    if (in_data.req_type == REQ_CLAIM) begin
      word = in_data.word_index;
    end else begin
      word = in_data.piece_num[PIECE_W-1:BIT_W];
    end
    cmd.addr     = word[MAP_AW-1:0];
    cmd.bit_sel  = in_data.piece_num[BIT_W-1:0];
    cmd.peer     = in_data.peer_word;
    cmd.last     = in_data.last_word;
    cmd.in_range = {1'b0, word} < (WORD_W + 1)'(MAP_BYTES);
  end

endmodule

/* hdl/pbce_queue.sv */
// Two-entry command queue between the decoder and the map sequencer.
module pbce_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  pbce_pkg::cmd_t push_cmd,
  input  logic           pop,
  output logic           full,
  output logic           not_empty,
  output pbce_pkg::cmd_t head
);
  import pbce_pkg::*;

  cmd_t              q [QDEPTH];
  logic [QPTR_W-1:0] wptr;
  logic [QPTR_W-1:0] rptr;
  logic [QCNT_W-1:0] count;

  assign full      = count == QCNT_W'(QDEPTH);
  assign not_empty = count != '0;
  assign head      = q[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + QPTR_W'(1);
      end
      if (pop) begin
        rptr <= rptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("Command pushed into a full queue.");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst) pop |-> not_empty)
    else $error("Command popped from an empty queue.");

endmodule

/* hdl/pbce_back.sv */
// Map sequencer with the piece bitmap, claim state, completeness walk and result register.
module pbce_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [pbce_pkg::COUNT_W-1:0] cfg_wdata,
  input  logic                        q_valid,
  input  pbce_pkg::cmd_t              head,
  output logic                        pop,
  output logic                        out_valid,
  input  logic                        out_ready,
  output pbce_pkg::resp_t             out_data
);
  import pbce_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_WALK,
    ST_EMIT
  } state_t;

  state_t                   state;
  cmd_t                     cmd;
  resp_t                    res;
  logic [COUNT_W-1:0]       piece_count;
  logic                     claim_taken;
  logic [PIECE_W-1:0]       claim_piece;
  logic [MAP_AW-1:0]        walk;

  logic [BITS_PER_WORD-1:0] mem [MAP_BYTES];
  logic                     vbit [MAP_BYTES];
  logic [BITS_PER_WORD-1:0] rd_data;
  logic                     rd_valid;

  logic [MAP_AW-1:0]        rd_addr;
  logic                     mem_we;
  logic [BITS_PER_WORD-1:0] mem_wdata;
  logic [COUNT_W-1:0]       usable;
  logic [BITS_PER_WORD-1:0] held;
  logic [BITS_PER_WORD-1:0] lim;
  logic [BITS_PER_WORD-1:0] cand;
  logic [BITS_PER_WORD-1:0] one_hot;
  logic [MAP_AW-1:0]        mask_word;
  logic [BIT_W-1:0]         pick;
  logic                     hit;
  logic                     taken_now;
  logic [PIECE_W-1:0]       piece_now;
  logic                     word_ok;
  logic                     walk_end;
  logic [MAP_AW:0]          walk_inc;
  logic                     slot_free;

  assign usable    = (piece_count < USABLE_CAP) ? piece_count : USABLE_CAP;
  assign held      = rd_valid ? rd_data : '0;
  assign pop       = (state == ST_IDLE) && q_valid;
  assign slot_free = !out_valid || out_ready;
  assign mask_word = (state == ST_WALK) ? walk : cmd.addr;
  assign one_hot   = BITS_PER_WORD'(1) << cmd.bit_sel;
  assign walk_inc  = {1'b0, walk} + (MAP_AW + 1)'(1);
  assign walk_end  = COUNT_W'({walk_inc, BIT_W'(0)}) >= usable;
  assign word_ok   = (held & lim) == lim;

  always_comb begin
    for (int b = 0; b < BITS_PER_WORD; b++) begin
      lim[b] = COUNT_W'({mask_word, BIT_W'(b)}) < usable;
    end
    cand = cmd.peer & ~held & lim;
    pick = '0;
    for (int b = BITS_PER_WORD - 1; b >= 0; b--) begin
      if (cand[b]) begin
        pick = BIT_W'(b);
      end
    end
    hit       = !claim_taken && cmd.in_range && (cand != '0);
    taken_now = claim_taken || hit;
    piece_now = hit ? PIECE_W'({cmd.addr, pick}) : claim_piece;
  end

  always_comb begin
    case (state)
      ST_IDLE: rd_addr = (head.op == OP_CHECK) ? '0 : head.addr;
      ST_WALK: rd_addr = walk_inc[MAP_AW-1:0];
      default: rd_addr = cmd.addr;
    endcase
    mem_we    = 1'b0;
    mem_wdata = held;
    if (state == ST_EXEC && cmd.in_range) begin
      case (cmd.op)
        OP_SET: begin
          mem_we    = 1'b1;
          mem_wdata = held | one_hot;
        end
        OP_CLEAR: begin
          mem_we    = 1'b1;
          mem_wdata = held & ~one_hot;
        end
        OP_CLAIM: begin
          mem_we    = hit;
          mem_wdata = held | (BITS_PER_WORD'(1) << pick);
        end
        default: mem_we = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[cmd.addr] <= mem_wdata;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAP_BYTES; i++) begin
        vbit[i] <= 1'b0;
      end
      rd_valid <= 1'b0;
    end else begin
      if (mem_we) begin
        vbit[cmd.addr] <= 1'b1;
      end
      rd_valid <= vbit[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      out_valid   <= 1'b0;
      claim_taken <= 1'b0;
      claim_piece <= '0;
      piece_count <= COUNT_RESET;
    end else begin
      if (cfg_we) begin
        piece_count <= cfg_wdata;
      end
      if (out_valid && out_ready && state != ST_EMIT) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (q_valid) begin
            cmd   <= head;
            walk  <= '0;
            state <= (head.op == OP_CHECK) ? ST_WALK : ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (cmd.op == OP_CLAIM && cmd.last) begin
            res.answer_kind   <= KIND_CLAIM;
            res.found         <= taken_now;
            res.claimed_piece <= taken_now ? piece_now : '0;
            res.complete      <= 1'b0;
            claim_taken       <= 1'b0;
            claim_piece       <= '0;
            state             <= ST_EMIT;
          end else begin
            state <= ST_IDLE;
            if (cmd.op == OP_CLAIM && hit) begin
              claim_taken <= 1'b1;
              claim_piece <= piece_now;
            end
          end
        end
        ST_WALK: begin
          if (!word_ok || walk_end) begin
            res.answer_kind   <= KIND_CHECK;
            res.found         <= 1'b0;
            res.claimed_piece <= '0;
            res.complete      <= word_ok;
            state             <= ST_EMIT;
          end else begin
            walk <= walk_inc[MAP_AW-1:0];
          end
        end
        ST_EMIT: begin
          if (slot_free) begin
            out_data  <= res;
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_walk_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WALK) |-> (walk == '0 || COUNT_W'({walk, BIT_W'(0)}) < usable))
    else $error("Completeness walk went past the pieces in use.");
  a_claim_end: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EXEC && cmd.op == OP_CLAIM && cmd.last) |=>
    (!claim_taken && state == ST_EMIT))
    else $error("Claim stream did not end on its last word.");
  a_check_fields: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.answer_kind == KIND_CHECK) |->
    (!out_data.found && out_data.claimed_piece == '0))
    else $error("Completeness answer carries claim fields.");
  a_pop_busy: assert property (@(posedge clk) disable iff (rst) pop |=> state != ST_IDLE)
    else $error("Popped command was not taken up.");

endmodule

/* hdl/piece_bitmap_claim_engine_top.sv */
// Top level of the piece bitmap claim engine: decoder, command queue and map sequencer.
//
//   channel  direction  handshake               payload
//   in       input      in_valid / in_ready     in_data  (pbce_pkg::req_t)
//   out      output     out_valid / out_ready   out_data (pbce_pkg::resp_t)
//   cfg      input      cfg_we                  cfg_wdata (piece_count)
//
// Set, clear and claim requests read the map byte, then write it.
// A claim request with the last word also loads the result register.
// A check request walks the map bytes in order, from one up to ceil(n/8)
// bytes with n the pieces in use; the walk stops at the first byte with an unmarked piece.
// Reset clears the map at once through one valid bit per byte; there is no clearing pass.
// A two-entry queue keeps taking requests while the sequencer is stalled on a full result.
module piece_bitmap_claim_engine_top (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [pbce_pkg::COUNT_W-1:0] cfg_wdata,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  pbce_pkg::req_t               in_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output pbce_pkg::resp_t              out_data
);
  import pbce_pkg::*;

  cmd_t push_cmd;
  cmd_t head;
  logic push;
  logic pop;
  logic full;
  logic not_empty;

  pbce_front u_front (
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .full     (full),
    .push     (push),
    .cmd      (push_cmd)
  );

  pbce_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_cmd  (push_cmd),
    .pop       (pop),
    .full      (full),
    .not_empty (not_empty),
    .head      (head)
  );

  pbce_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .q_valid   (not_empty),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

/* verif/tb.sv */
// Self-checking testbench for the piece bitmap claim engine: directed table, then random phases.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pbce_pkg::*;

  localparam int SETTLE_CYCLES = 300;
  localparam int LIMIT_NS      = 4_000_000;

  typedef struct {
    req_t  req;
    bit    typed;
    resp_t ans;
  } row_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_we = 1'b0;
  logic [COUNT_W-1:0]  cfg_wdata = '0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  req_t                in_data = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  resp_t               out_data;

  logic [BITS_PER_WORD-1:0] held_map [MAP_BYTES];
  logic [COUNT_W-1:0]       piece_count_now = COUNT_RESET;
  bit                       stream_taken = 1'b0;
  logic [PIECE_W-1:0]       stream_piece = '0;

  resp_t pending_answers [$];
  row_t  directed_plan [$];
  resp_t oldest_answer;
  int    mismatches = 0;
  int    requests_sent = 0;
  int    sender_idle_pct = 0;
  int    recv_stall_pct = 0;

  piece_bitmap_claim_engine_top uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #(LIMIT_NS);
    $display("Regression FAIL");
    $finish;
  end

  task automatic apply_request(input req_t r, output bit gives, output resp_t ans);
    int usable;
    int w;
    int b;
    int i;
    int piece;
    logic [BITS_PER_WORD-1:0] cand;
    gives = 1'b0;
    ans = '0;
    usable = (piece_count_now < USABLE_CAP) ? int'(piece_count_now) : MAP_BYTES * BITS_PER_WORD;
    w = int'(r.piece_num) / BITS_PER_WORD;
    b = int'(r.piece_num) % BITS_PER_WORD;
    case (op_t'(r.req_type))
      OP_SET: begin
        if (w < MAP_BYTES) held_map[w][b] = 1'b1;
      end
      OP_CLEAR: begin
        if (w < MAP_BYTES) held_map[w][b] = 1'b0;
      end
      OP_CHECK: begin
        gives = 1'b1;
        ans.answer_kind = KIND_CHECK;
        ans.complete = 1'b1;
        for (i = 0; i < usable; i++) begin
          if (!held_map[i / BITS_PER_WORD][i % BITS_PER_WORD]) ans.complete = 1'b0;
        end
      end
      OP_CLAIM: begin
        w = int'(r.word_index);
        if (!stream_taken && w < MAP_BYTES) begin
          cand = r.peer_word & ~held_map[w];
          for (b = 0; b < BITS_PER_WORD; b++) begin
            piece = w * BITS_PER_WORD + b;
            if (!stream_taken && piece < usable && cand[b]) begin
              held_map[w][b] = 1'b1;
              stream_taken = 1'b1;
              stream_piece = PIECE_W'(piece);
            end
          end
        end
        if (r.last_word) begin
          gives = 1'b1;
          ans.answer_kind = KIND_CLAIM;
          ans.found = stream_taken;
          ans.claimed_piece = stream_taken ? stream_piece : '0;
          stream_taken = 1'b0;
          stream_piece = '0;
        end
      end
      default: ;
    endcase
  endtask

  task automatic send_request(input req_t r, input bit typed, input resp_t typed_ans);
    bit    gives;
    resp_t ans;
    @(negedge clk);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    apply_request(r, gives, ans);
    if (gives) pending_answers.push_back(typed ? typed_ans : ans);
    requests_sent++;
  endtask

  task automatic drain_answers();
    @(negedge clk);
    in_valid <= 1'b0;
    wait (pending_answers.size() == 0);
  endtask

  task automatic configure(input int value);
    drain_answers();
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= COUNT_W'(value);
    piece_count_now = COUNT_W'(value);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic req_t mk(op_t op, int pidx, int pword, int widx, int last);
    req_t r;
    r.req_type = op;
    r.piece_num = PIECE_W'(pidx);
    r.peer_word = 8'(pword);
    r.word_index = WORD_W'(widx);
    r.last_word = 1'(last);
    return r;
  endfunction

  function automatic resp_t answer(logic kind, int hit, int piece, int done);
    resp_t a;
    a.answer_kind = kind;
    a.found = 1'(hit);
    a.claimed_piece = PIECE_W'(piece);
    a.complete = 1'(done);
    return a;
  endfunction

  task automatic plan_row(input req_t r, input bit typed, input resp_t ans);
    directed_plan.push_back('{r, typed, ans});
  endtask

  function automatic req_t noise_fields();
    return mk(op_t'($urandom_range(0, 3)), $urandom_range(0, 1023), $urandom_range(0, 255),
              $urandom_range(0, 127), $urandom_range(0, 1));
  endfunction

  function automatic int focus_word();
    int top;
    top = int'(piece_count_now) / BITS_PER_WORD + 1;
    if (top > MAP_BYTES - 1) top = MAP_BYTES - 1;
    if ($urandom_range(0, 4) == 0) return $urandom_range(0, MAP_BYTES - 1);
    return $urandom_range(0, top);
  endfunction

  function automatic int focus_piece();
    int top;
    top = int'(piece_count_now) + 7;
    if (top > 1023) top = 1023;
    if ($urandom_range(0, 4) == 0) return $urandom_range(0, 1023);
    return $urandom_range(0, top);
  endfunction

  function automatic int peer_pattern();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      2, 3: return 1 << $urandom_range(0, 7);
      default: return $urandom_range(0, 255);
    endcase
  endfunction

  function automatic req_t single_request();
    req_t r;
    int pick;
    r = noise_fields();
    pick = $urandom_range(0, 99);
    r.req_type = (pick < 45) ? OP_SET : (pick < 75) ? OP_CLEAR : OP_CHECK;
    r.piece_num = PIECE_W'(focus_piece());
    return r;
  endfunction

  task automatic claim_stream(input bit scrambled);
    int   len;
    int   start;
    req_t r;
    len = $urandom_range(1, 6);
    start = focus_word();
    for (int k = 0; k < len; k++) begin
      if ($urandom_range(0, 9) == 0) send_request(single_request(), 1'b0, '0);
      r = noise_fields();
      r.req_type = OP_CLAIM;
      r.word_index = WORD_W'(scrambled ? focus_word() : start + k);
      r.peer_word = 8'(peer_pattern());
      r.last_word = (k == len - 1) || (scrambled && $urandom_range(0, 7) == 0);
      send_request(r, 1'b0, '0);
    end
  endtask

  task automatic run_phase(input int count, input int s_idle, input int r_stall, input int n);
    int stop;
    int pick;
    configure(count);
    sender_idle_pct = s_idle;
    recv_stall_pct = r_stall;
    stop = requests_sent + n;
    while (requests_sent < stop) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) claim_stream(1'b0);
      else if (pick < 63) claim_stream(1'b1);
      else if (pick < 95) send_request(single_request(), 1'b0, '0);
      else send_request(noise_fields(), 1'b0, '0);
      if ($urandom_range(0, 199) == 0) drain_answers();
    end
  endtask

  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_answers.size() == 0) begin
        $error("unexpected answer %p", out_data);
        mismatches++;
      end else begin
        oldest_answer = pending_answers.pop_front();
        if (out_data.answer_kind !== oldest_answer.answer_kind) begin
          $error("answer_kind: expected %0d, got %0d", oldest_answer.answer_kind,
                 out_data.answer_kind);
          mismatches++;
        end
        if (out_data.found !== oldest_answer.found) begin
          $error("found: expected %0d, got %0d", oldest_answer.found, out_data.found);
          mismatches++;
        end
        if (out_data.claimed_piece !== oldest_answer.claimed_piece) begin
          $error("claimed_piece: expected %0d, got %0d", oldest_answer.claimed_piece,
                 out_data.claimed_piece);
          mismatches++;
        end
        if (out_data.complete !== oldest_answer.complete) begin
          $error("complete: expected %0d, got %0d", oldest_answer.complete, out_data.complete);
          mismatches++;
        end
      end
    end
  end

  initial begin
    foreach (held_map[i]) held_map[i] = '0;

    // The out-of-order stream and the clear inside a stream both rely on the
    // piece taken by the first word being kept until the last word.
    plan_row(mk(OP_CHECK, 1023, 'hFF, 127, 1), 1'b1, answer(KIND_CHECK, 0, 0, 0));
    plan_row(mk(OP_CLAIM, 1023, 'h01, 0, 1), 1'b1, answer(KIND_CLAIM, 1, 0, 0));
    plan_row(mk(OP_CLAIM, 0, 'h01, 0, 1), 1'b1, answer(KIND_CLAIM, 0, 0, 0));
    plan_row(mk(OP_SET, 1023, 'h00, 0, 0), 1'b0, '0);
    plan_row(mk(OP_CLAIM, 0, 'hFF, 127, 1), 1'b1, answer(KIND_CLAIM, 1, 1016, 0));
    plan_row(mk(OP_CLEAR, 1023, 'hFF, 127, 1), 1'b0, '0);
    plan_row(mk(OP_CLAIM, 0, 'h10, 5, 0), 1'b0, '0);
    plan_row(mk(OP_CLAIM, 0, 'hFF, 2, 0), 1'b0, '0);
    plan_row(mk(OP_CLAIM, 0, 'h00, 3, 1), 1'b1, answer(KIND_CLAIM, 1, 44, 0));
    plan_row(mk(OP_CLAIM, 0, 'h02, 10, 0), 1'b0, '0);
    plan_row(mk(OP_SET, 500, 'h00, 0, 0), 1'b0, '0);
    plan_row(mk(OP_CHECK, 0, 'h00, 0, 0), 1'b1, answer(KIND_CHECK, 0, 0, 0));
    plan_row(mk(OP_CLEAR, 81, 'h00, 0, 0), 1'b0, '0);
    plan_row(mk(OP_CLAIM, 0, 'hFF, 11, 1), 1'b1, answer(KIND_CLAIM, 1, 81, 0));
    plan_row(mk(OP_CLAIM, 0, 'h00, 64, 1), 1'b1, answer(KIND_CLAIM, 0, 0, 0));
    plan_row(mk(OP_CLAIM, 0, 'hFF, 127, 1), 1'b0, '0);
    plan_row(mk(OP_CLAIM, 0, 'h80, 127, 0), 1'b0, '0);
    plan_row(mk(OP_CLAIM, 0, 'hFF, 126, 1), 1'b0, '0);
    plan_row(mk(OP_SET, 512, 'h00, 0, 0), 1'b0, '0);
    plan_row(mk(OP_CLEAR, 0, 'h00, 0, 0), 1'b0, '0);
    plan_row(mk(OP_CLAIM, 0, 'h01, 0, 1), 1'b1, answer(KIND_CLAIM, 1, 0, 0));
    plan_row(mk(OP_CHECK, 0, 'h00, 0, 0), 1'b0, '0);
    plan_row(mk(OP_CLAIM, 0, 'hAA, 42, 1), 1'b0, '0);

    repeat (12) @(negedge clk);
    rst <= 1'b0;

    foreach (directed_plan[i]) begin
      send_request(directed_plan[i].req, directed_plan[i].typed, directed_plan[i].ans);
    end

    run_phase(1024, 0, 0, 200);
    run_phase(0, 73, 0, 100);
    run_phase(1, 0, 73, 100);
    run_phase(2047, 19, 19, 150);
    run_phase(9, 0, 0, 150);
    run_phase(37, 73, 0, 150);
    run_phase($urandom_range(2, 1023), 0, 73, 150);
    run_phase(64, 19, 19, 150);
    run_phase(1024, 0, 0, 150);

    drain_answers();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* sim.f */
hdl/pbce_pkg.sv
hdl/pbce_front.sv
hdl/pbce_queue.sv
hdl/pbce_back.sv
hdl/piece_bitmap_claim_engine_top.sv
verif/tb.sv
